// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the block cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`define ASSERT_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

// File: design/rc2sbc_pkg.sv
// Package with the constants, codes and S-box of the block cipher.
`timescale 1ns / 1ps
`default_nettype none

package rc2sbc_pkg;

    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 3;

    localparam int KEY_BYTES = 128;
    localparam int KEY_ROWS  = 64;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ENCRYPT = 2'd1;
    localparam logic [1:0] REQ_DECRYPT = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_KEY    = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

    localparam logic [3:0] LAST_ROUND = 4'd15;
    localparam logic [3:0] MASH_ENC_A = 4'd4;
    localparam logic [3:0] MASH_ENC_B = 4'd10;
    localparam logic [3:0] MASH_DEC_A = 4'd5;
    localparam logic [3:0] MASH_DEC_B = 4'd11;

    localparam logic [11:0] SBOX_SRC [256] = '{
        12'd71, 12'd194, 12'd38, 12'd1701, 12'd89, 12'd76, 12'd11, 12'd83,
        12'd1629, 12'd48, 12'd94, 12'd63, 12'd132, 12'd16, 12'd111, 12'd95,
        12'd84, 12'd341, 12'd975, 12'd14, 12'd40, 12'd64, 12'd27, 12'd81,
        12'd139, 12'd213, 12'd63, 12'd90, 12'd1120, 12'd8, 12'd15, 12'd3,
        12'd126, 12'd2018, 12'd40, 12'd74, 12'd758, 12'd485, 12'd604, 12'd230,
        12'd436, 12'd664, 12'd582, 12'd150, 12'd251, 12'd284, 12'd308, 12'd231,
        12'd124, 12'd211, 12'd486, 12'd225, 12'd401, 12'd370, 12'd11, 12'd101,
        12'd305, 12'd139, 12'd189, 12'd17, 12'd33, 12'd88, 12'd208, 12'd193,
        12'd145, 12'd1, 12'd94, 12'd73, 12'd416, 12'd918, 12'd263, 12'd28,
        12'd500, 12'd538, 12'd356, 12'd117, 12'd136, 12'd219, 12'd27, 12'd176,
        12'd130, 12'd10, 12'd460, 12'd25, 12'd485, 12'd18, 12'd436, 12'd65,
        12'd84, 12'd200, 12'd283, 12'd118, 12'd320, 12'd138, 12'd36, 12'd416,
        12'd280, 12'd15, 12'd71, 12'd224, 12'd961, 12'd44, 12'd16, 12'd401,
        12'd39, 12'd88, 12'd61, 12'd304, 12'd12, 12'd21, 12'd24, 12'd283,
        12'd134, 12'd92, 12'd63, 12'd246, 12'd486, 12'd682, 12'd7, 12'd219,
        12'd184, 12'd360, 12'd780, 12'd18, 12'd64, 12'd463, 12'd474, 12'd131,
        12'd160, 12'd79, 12'd73, 12'd440, 12'd95, 12'd18, 12'd64, 12'd581,
        12'd34, 12'd69, 12'd128, 12'd367, 12'd460, 12'd17, 12'd81, 12'd12,
        12'd103, 12'd820, 12'd62, 12'd110, 12'd97, 12'd103, 12'd862, 12'd70,
        12'd60, 12'd1317, 12'd471, 12'd540, 12'd208, 12'd121, 12'd890, 12'd346,
        12'd36, 12'd150, 12'd59, 12'd568, 12'd614, 12'd13, 12'd120, 12'd63,
        12'd219, 12'd812, 12'd2160, 12'd1780, 12'd99, 12'd35, 12'd18, 12'd21,
        12'd136, 12'd872, 12'd15, 12'd28, 12'd170, 12'd88, 12'd4, 12'd30,
        12'd44, 12'd112, 12'd18, 12'd147, 12'd436, 12'd195, 12'd320, 12'd37,
        12'd122, 12'd113, 12'd6, 12'd140, 12'd8, 12'd120, 12'd305, 12'd42,
        12'd58, 12'd461, 12'd44, 12'd106, 12'd301, 12'd13, 12'd408, 12'd680,
        12'd93, 12'd86, 12'd116, 12'd530, 12'd82, 12'd568, 12'd9, 12'd102,
        12'd38, 12'd416, 12'd89, 12'd71, 12'd216, 12'd728, 12'd965, 12'd818,
        12'd2, 12'd38, 12'd121, 12'd195, 12'd14, 12'd326, 12'd148, 12'd234,
        12'd18, 12'd55, 12'd131, 12'd234, 12'd361, 12'd824, 12'd5, 12'd81,
        12'd623, 12'd48, 12'd961, 12'd19, 12'd26, 12'd33, 12'd10, 12'd1101,
        12'd365, 12'd92, 12'd88, 12'd181, 12'd275, 12'd346, 12'd201, 12'd206
    };

    localparam logic [7:0] SBOX_PAD [256] = '{
        8'd158, 8'd186, 8'd223, 8'd97, 8'd64, 8'd145, 8'd190, 8'd190,
        8'd117, 8'd217, 8'd163, 8'd70, 8'd206, 8'd176, 8'd183, 8'd194,
        8'd146, 8'd43, 8'd248, 8'd141, 8'd3, 8'd54, 8'd72, 8'd223,
        8'd233, 8'd153, 8'd91, 8'd210, 8'd36, 8'd131, 8'd244, 8'd161,
        8'd105, 8'd120, 8'd113, 8'd191, 8'd113, 8'd86, 8'd19, 8'd245,
        8'd213, 8'd221, 8'd43, 8'd27, 8'd242, 8'd157, 8'd73, 8'd213,
        8'd193, 8'd92, 8'd166, 8'd10, 8'd23, 8'd197, 8'd112, 8'd110,
        8'd193, 8'd30, 8'd156, 8'd51, 8'd125, 8'd51, 8'd158, 8'd67,
        8'd197, 8'd215, 8'd59, 8'd218, 8'd110, 8'd246, 8'd181, 8'd0,
        8'd135, 8'd76, 8'd164, 8'd97, 8'd47, 8'd87, 8'd234, 8'd108,
        8'd144, 8'd127, 8'd6, 8'd6, 8'd222, 8'd172, 8'd80, 8'd144,
        8'd22, 8'd245, 8'd207, 8'd70, 8'd227, 8'd182, 8'd146, 8'd134,
        8'd119, 8'd176, 8'd73, 8'd58, 8'd135, 8'd69, 8'd23, 8'd198,
        8'd0, 8'd170, 8'd32, 8'd171, 8'd176, 8'd129, 8'd91, 8'd24,
        8'd126, 8'd77, 8'd248, 8'd0, 8'd118, 8'd69, 8'd57, 8'd60,
        8'd190, 8'd171, 8'd217, 8'd61, 8'd136, 8'd169, 8'd196, 8'd84,
        8'd168, 8'd167, 8'd163, 8'd102, 8'd223, 8'd64, 8'd174, 8'd178,
        8'd166, 8'd239, 8'd242, 8'd195, 8'd249, 8'd92, 8'd59, 8'd38,
        8'd241, 8'd46, 8'd236, 8'd31, 8'd59, 8'd114, 8'd23, 8'd50,
        8'd119, 8'd186, 8'd7, 8'd66, 8'd212, 8'd97, 8'd222, 8'd182,
        8'd230, 8'd118, 8'd122, 8'd86, 8'd105, 8'd92, 8'd179, 8'd243,
        8'd255, 8'd189, 8'd223, 8'd164, 8'd194, 8'd215, 8'd98, 8'd44,
        8'd17, 8'd20, 8'd53, 8'd153, 8'd137, 8'd224, 8'd176, 8'd100,
        8'd208, 8'd114, 8'd36, 8'd200, 8'd145, 8'd150, 8'd215, 8'd20,
        8'd87, 8'd44, 8'd252, 8'd20, 8'd235, 8'd242, 8'd163, 8'd132,
        8'd63, 8'd18, 8'd5, 8'd122, 8'd74, 8'd97, 8'd34, 8'd97,
        8'd142, 8'd86, 8'd146, 8'd221, 8'd179, 8'd166, 8'd161, 8'd74,
        8'd69, 8'd182, 8'd88, 8'd120, 8'd128, 8'd58, 8'd76, 8'd155,
        8'd15, 8'd30, 8'd77, 8'd216, 8'd165, 8'd117, 8'd107, 8'd90,
        8'd169, 8'd127, 8'd143, 8'd181, 8'd208, 8'd137, 8'd200, 8'd127,
        8'd170, 8'd195, 8'd26, 8'd84, 8'd255, 8'd132, 8'd150, 8'd58,
        8'd103, 8'd250, 8'd120, 8'd221, 8'd237, 8'd37, 8'd8, 8'd99
    };

    function automatic logic [7:0] sbox_at(input logic [7:0] idx);
        return SBOX_SRC[idx][7:0] ^ SBOX_PAD[idx];
    endfunction

endpackage

`default_nettype wire

// File: design/rc2_style_block_cipher_top.sv
// Top level of the 64-bit block cipher with byte-wise key loading and expansion.
//
// The slave stream takes one request at a time. tuser selects a key byte load,
// an encryption or a decryption; tdata carries the key index, the key byte and
// the four data words. The master stream returns one result per request: the
// four result words in tdata, the status code and the key ready flag in tuser.
// Configuration is a single key length register, written with cfg_wen.
// The key lives in two 64 x 8 RAMs (even and odd bytes), so one key word is
// read per cycle from registered read ports.
// Encryption and decryption run one subround or mash step per cycle through
// the key word read port; the result then passes through ST_RESULT into the
// output register.
// The load of the last key byte starts the expansion, one byte per cycle up to
// byte 127, followed by a final S-box pass on byte zero.
// Other requests pass through ST_RESULT into the output register.
// A new request is taken from the cycle after the previous result has moved
// into the output register. After reset no key is valid and key_length is 16.
// When the receiver stalls, the result waits in the output register and the
// next result waits in the block, which then takes no new request.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rc2_style_block_cipher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_index[6:0], key_byte[14:7], in_word0..in_word3 from bit 15 up, zero
    input  logic [rc2sbc_pkg::S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [rc2sbc_pkg::S_USER_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_word0[15:0], out_word1[31:16], out_word2[47:32], out_word3[63:48]
    output logic [rc2sbc_pkg::M_DATA_W-1:0] m_tdata,
    // status[1:0], key_ready[2]
    output logic [rc2sbc_pkg::M_USER_W-1:0] m_tuser,
    input  logic                            cfg_wen,
    input  logic [7:0]                      cfg_wdata
);

    import rc2sbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FINAL,
        ST_CIPHER,
        ST_RESULT
    } state_t;

    state_t                state_reg;
    logic [7:0]            key_length_reg;
    logic                  key_valid_reg;
    logic [15:0]           w_reg [4];
    logic [1:0]            status_reg;
    logic                  decrypt_reg;
    logic [3:0]            rnd_reg;
    logic [1:0]            sub_reg;
    logic                  mash_reg;
    logic [6:0]            j_reg;
    logic [7:0]            prev_reg;
    logic                  sel_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [M_USER_W-1:0]   m_tuser_reg;

    logic [7:0]  eff_len;
    logic        accept;
    logic [6:0]  key_index;
    logic [7:0]  key_byte;
    logic [15:0] in_word [4];
    logic        idx_in_range;
    logic        idx_is_last;

    logic [7:0]  even_q;
    logic [7:0]  odd_q;
    logic [15:0] kword;
    logic        we;
    logic        we_even;
    logic        we_odd;
    logic [6:0]  wr_addr;
    logic [7:0]  wr_byte;
    logic [5:0]  rd_row;
    logic        rd_sel;

    logic [15:0] a_w, b_w, c_w, d_w;
    logic [15:0] mix;
    logic [15:0] enc_sum;
    logic [15:0] enc_rot;
    logic [15:0] a_ror;
    logic [15:0] new_word;
    logic [15:0] w_upd [4];
    logic [3:0]  next_rnd;
    logic [1:0]  next_sub;
    logic        next_mash;
    logic        last_op;
    logic [15:0] mash_src;
    logic [5:0]  cipher_row;
    logic [3:0]  init_rnd;
    logic [1:0]  init_sub;

    logic [7:0]  exp_src;
    logic [7:0]  exp_sum;
    logic [7:0]  exp_new;
    logic [6:0]  j_inc;
    logic [6:0]  exp_rd_byte;
    logic        exp_last;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign key_index = s_tdata[6:0];
    assign key_byte  = s_tdata[14:7];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            in_word[k] = s_tdata[15 + 16 * k +: 16];
        end
    end

    always_comb
    begin
        if (key_length_reg == 8'd0)
        begin
            eff_len = 8'd1;
        end
        else if (key_length_reg > 8'(KEY_BYTES))
        begin
            eff_len = 8'(KEY_BYTES);
        end
        else
        begin
            eff_len = key_length_reg;
        end
    end

    assign idx_in_range = ({1'b0, key_index} < eff_len);
    assign idx_is_last  = ({1'b0, key_index} == (eff_len - 8'd1));

    assign kword = {odd_q, even_q};

    always_comb
    begin
        unique case (sub_reg)
            2'd0:
            begin
                a_w = w_reg[0]; b_w = w_reg[1]; c_w = w_reg[2]; d_w = w_reg[3];
            end
            2'd1:
            begin
                a_w = w_reg[1]; b_w = w_reg[2]; c_w = w_reg[3]; d_w = w_reg[0];
            end
            2'd2:
            begin
                a_w = w_reg[2]; b_w = w_reg[3]; c_w = w_reg[0]; d_w = w_reg[1];
            end
            default:
            begin
                a_w = w_reg[3]; b_w = w_reg[0]; c_w = w_reg[1]; d_w = w_reg[2];
            end
        endcase
    end

    assign mix     = (b_w & ~d_w) + (c_w & d_w);
    assign enc_sum = a_w + mix + kword;

    always_comb
    begin
        unique case (sub_reg)
            2'd0:
            begin
                enc_rot = {enc_sum[14:0], enc_sum[15]};
                a_ror   = {a_w[0], a_w[15:1]};
            end
            2'd1:
            begin
                enc_rot = {enc_sum[13:0], enc_sum[15:14]};
                a_ror   = {a_w[1:0], a_w[15:2]};
            end
            2'd2:
            begin
                enc_rot = {enc_sum[12:0], enc_sum[15:13]};
                a_ror   = {a_w[2:0], a_w[15:3]};
            end
            default:
            begin
                enc_rot = {enc_sum[10:0], enc_sum[15:11]};
                a_ror   = {a_w[4:0], a_w[15:5]};
            end
        endcase
    end

    always_comb
    begin
        if (mash_reg)
        begin
            new_word = decrypt_reg ? (a_w - kword) : (a_w + kword);
        end
        else
        begin
            new_word = decrypt_reg ? (a_ror - mix - kword) : enc_rot;
        end
        for (int k = 0; k < 4; k++)
        begin
            w_upd[k] = (2'(k) == sub_reg) ? new_word : w_reg[k];
        end
    end

    always_comb
    begin
        next_rnd  = rnd_reg;
        next_sub  = sub_reg;
        next_mash = mash_reg;
        last_op   = 1'b0;
        if (!decrypt_reg)
        begin
            if (sub_reg != 2'd3)
            begin
                next_sub = sub_reg + 2'd1;
            end
            else if (!mash_reg && (rnd_reg == MASH_ENC_A || rnd_reg == MASH_ENC_B))
            begin
                next_mash = 1'b1;
                next_sub  = 2'd0;
            end
            else
            begin
                next_mash = 1'b0;
                next_sub  = 2'd0;
                next_rnd  = rnd_reg + 4'd1;
                last_op   = (rnd_reg == LAST_ROUND);
            end
        end
        else
        begin
            if (sub_reg != 2'd0)
            begin
                next_sub = sub_reg - 2'd1;
            end
            else if (!mash_reg && (rnd_reg == MASH_DEC_A || rnd_reg == MASH_DEC_B))
            begin
                next_mash = 1'b1;
                next_sub  = 2'd3;
            end
            else
            begin
                next_mash = 1'b0;
                next_sub  = 2'd3;
                next_rnd  = rnd_reg - 4'd1;
                last_op   = (rnd_reg == 4'd0);
            end
        end
    end

    always_comb
    begin
        unique case (next_sub)
            2'd0:    mash_src = w_upd[3];
            2'd1:    mash_src = w_upd[0];
            2'd2:    mash_src = w_upd[1];
            default: mash_src = w_upd[2];
        endcase
        cipher_row = next_mash ? mash_src[5:0] : {next_rnd, next_sub};
    end

    assign init_rnd = (s_tuser == REQ_DECRYPT) ? LAST_ROUND : 4'd0;
    assign init_sub = (s_tuser == REQ_DECRYPT) ? 2'd3 : 2'd0;

    // With a one-byte key every source byte is the byte written just before.
    assign exp_src     = (eff_len == 8'd1) ? prev_reg : (sel_reg ? odd_q : even_q);
    assign exp_sum     = exp_src + prev_reg;
    assign exp_new     = sbox_at(exp_sum);
    assign j_inc       = j_reg + 7'd1;
    assign exp_rd_byte = j_inc - eff_len[6:0];
    assign exp_last    = (j_reg == 7'(KEY_BYTES - 1));

    always_comb
    begin
        we      = 1'b0;
        wr_addr = key_index;
        wr_byte = key_byte;
        rd_row  = 6'd0;
        rd_sel  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_row = {init_rnd, init_sub};
                we     = accept && (s_tuser == REQ_LOAD) && idx_in_range;
            end
            ST_EXPAND:
            begin
                we      = 1'b1;
                wr_addr = j_reg;
                wr_byte = exp_new;
                if (!exp_last)
                begin
                    rd_row = exp_rd_byte[6:1];
                    rd_sel = exp_rd_byte[0];
                end
            end
            ST_FINAL:
            begin
                we      = 1'b1;
                wr_addr = 7'd0;
                wr_byte = sbox_at(even_q);
            end
            ST_CIPHER:
            begin
                rd_row = cipher_row;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign we_even = we && !wr_addr[0];
    assign we_odd  = we && wr_addr[0];

    rc2sbc_ram #(
        .WIDTH (8),
        .DEPTH (KEY_ROWS)
    ) u_even_ram (
        .clk   (clk),
        .we    (we_even),
        .waddr (wr_addr[6:1]),
        .wdata (wr_byte),
        .raddr (rd_row),
        .rdata (even_q)
    );

    rc2sbc_ram #(
        .WIDTH (8),
        .DEPTH (KEY_ROWS)
    ) u_odd_ram (
        .clk   (clk),
        .we    (we_odd),
        .waddr (wr_addr[6:1]),
        .wdata (wr_byte),
        .raddr (rd_row),
        .rdata (odd_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_length_reg <= 8'd16;
            key_valid_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                w_reg[k] <= 16'd0;
            end
            status_reg     <= STAT_OK;
            decrypt_reg    <= 1'b0;
            rnd_reg        <= 4'd0;
            sub_reg        <= 2'd0;
            mash_reg       <= 1'b0;
            j_reg          <= 7'd0;
            prev_reg       <= 8'd0;
            sel_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                key_length_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            sel_reg <= rd_sel;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (s_tuser == REQ_LOAD)
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                w_reg[k] <= 16'd0;
                            end
                            if (!idx_in_range)
                            begin
                                status_reg <= STAT_BAD_INDEX;
                                state_reg  <= ST_RESULT;
                            end
                            else
                            begin
                                status_reg    <= STAT_OK;
                                key_valid_reg <= 1'b0;
                                if (idx_is_last)
                                begin
                                    j_reg    <= eff_len[6:0];
                                    prev_reg <= key_byte;
                                    state_reg <= (eff_len == 8'(KEY_BYTES)) ? ST_FINAL
                                                                            : ST_EXPAND;
                                end
                                else
                                begin
                                    state_reg <= ST_RESULT;
                                end
                            end
                        end
                        else if (s_tuser == REQ_ENCRYPT || s_tuser == REQ_DECRYPT)
                        begin
                            if (!key_valid_reg)
                            begin
                                status_reg <= STAT_NO_KEY;
                                for (int k = 0; k < 4; k++)
                                begin
                                    w_reg[k] <= 16'd0;
                                end
                                state_reg <= ST_RESULT;
                            end
                            else
                            begin
                                status_reg <= STAT_OK;
                                for (int k = 0; k < 4; k++)
                                begin
                                    w_reg[k] <= in_word[k];
                                end
                                decrypt_reg <= (s_tuser == REQ_DECRYPT);
                                rnd_reg     <= init_rnd;
                                sub_reg     <= init_sub;
                                mash_reg    <= 1'b0;
                                state_reg   <= ST_CIPHER;
                            end
                        end
                        else
                        begin
                            status_reg <= STAT_OK;
                            for (int k = 0; k < 4; k++)
                            begin
                                w_reg[k] <= 16'd0;
                            end
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_EXPAND:
                begin
                    prev_reg <= exp_new;
                    j_reg    <= j_inc;
                    if (exp_last)
                    begin
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    key_valid_reg <= 1'b1;
                    state_reg     <= ST_RESULT;
                end
                ST_CIPHER:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        w_reg[k] <= w_upd[k];
                    end
                    rnd_reg  <= next_rnd;
                    sub_reg  <= next_sub;
                    mash_reg <= next_mash;
                    if (last_op)
                    begin
                        state_reg <= ST_RESULT;
                    end
                end
                default:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {w_reg[3], w_reg[2], w_reg[1], w_reg[0]};
                        m_tuser_reg  <= {key_valid_reg, status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_NXT(a_one_request, clk, rst_n, s_tvalid && s_tready, !s_tready, "request overlap")
    `ASSERT_NEVER(a_no_write_cipher, clk, rst_n, state_reg == ST_CIPHER && we, "cipher key write")
    `ASSERT_IMP(a_mash_round, clk, rst_n, state_reg == ST_CIPHER && mash_reg && !decrypt_reg, rnd_reg == MASH_ENC_A || rnd_reg == MASH_ENC_B, "mash step in wrong round")
    `ASSERT_NXT(a_key_after_final, clk, rst_n, state_reg == ST_FINAL, key_valid_reg, "key not valid after expansion")

endmodule

`default_nettype wire

// File: design/rc2sbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rc2sbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
